### rtl/fwrt_pkg.sv
package fwrt_pkg;

    // Field widths
    localparam int MODE_W      = 2;
    localparam int TAG_W       = 8;
    localparam int HANDLE_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 32;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ENQ    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // Controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Controller to datapath commands
    typedef struct packed
    {
        logic accept;   // latch the incoming transaction and compare tags
        logic exec;     // apply the operation and load the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed
    {
        logic out_busy; // result register holds a transaction not taken this cycle
    } stat_t;

endpackage

### rtl/fifo_with_remove_by_tag_unit.sv
// Order-keeping work queue with removal by tag.
//
// Slave stream (s_*): one operation per transaction. tdata carries, from the
// lowest bit: mode (0 enqueue, 1 dequeue front, 2 remove oldest entry with
// tag), tag, work_handle. Master stream (m_*): exactly one result transaction
// per operation, in order: status, removed_valid, removed_tag,
// removed_handle, now_empty.
//
// Entries sit in a row of DEPTH cells, front at cell 0. A tag compare runs
// across all occupied cells in parallel when the operation is accepted; in
// the execute step the oldest match is picked, echoed, and the cells behind it
// shift forward one place to close the gap.
// The result is loaded into the output register by the execute step. Operations
// do not overlap: accept step, then execute step, then the next accept.
// The result sits in an output register; a stalled receiver holds the
// current operation in its execute cycle until the register drains, and the
// next operation is not accepted until then.
// Reset empties the queue and drops any pending result; cell contents are
// not cleared and are never read past the fill count.
module fifo_with_remove_by_tag_unit
#(
    parameter int DEPTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fwrt_pkg::S_TDATA_W-1:0]   s_tdata,  // mode[1:0], tag[9:2], work_handle[25:10]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fwrt_pkg::M_TDATA_W-1:0]   m_tdata   // status[1:0], removed_valid[2],
                                                       // removed_tag[10:3],
                                                       // removed_handle[26:11], now_empty[27]
);

    localparam int TAG_LO = fwrt_pkg::MODE_W;
    localparam int HND_LO = TAG_LO + fwrt_pkg::TAG_W;
    localparam int IN_W   = HND_LO + fwrt_pkg::HANDLE_W;
    localparam int OUT_W  = fwrt_pkg::STATUS_W + 1 + fwrt_pkg::TAG_W + fwrt_pkg::HANDLE_W + 1;

    fwrt_pkg::cmd_t  cmd;
    fwrt_pkg::stat_t stat;

    logic [fwrt_pkg::STATUS_W-1:0] status;
    logic                          removed_valid;
    logic [fwrt_pkg::TAG_W-1:0]    removed_tag;
    logic [fwrt_pkg::HANDLE_W-1:0] removed_handle;
    logic                          now_empty;
    logic [IN_W-1:0]               in_fields;

    assign in_fields = s_tdata[IN_W-1:0];

    fwrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fwrt_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .in_mode            (in_fields[fwrt_pkg::MODE_W-1:0]),
        .in_tag             (in_fields[HND_LO-1:TAG_LO]),
        .in_handle          (in_fields[IN_W-1:HND_LO]),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_status         (status),
        .out_removed_valid  (removed_valid),
        .out_removed_tag    (removed_tag),
        .out_removed_handle (removed_handle),
        .out_now_empty      (now_empty)
    );

    // Pack the result fields, lowest first, zero filled to the byte
    assign m_tdata = {{(fwrt_pkg::M_TDATA_W - OUT_W){1'b0}},
                      now_empty, removed_handle, removed_tag, removed_valid, status};

endmodule

### rtl/fwrt_ctrl.sv
module fwrt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  fwrt_pkg::stat_t stat,
    output fwrt_pkg::cmd_t  cmd
);

    fwrt_pkg::state_t state_reg;
    fwrt_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwrt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            fwrt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = fwrt_pkg::ST_EXEC;
                end
            end
            fwrt_pkg::ST_EXEC:
            begin
                // wait for the result register to drain
                if (!stat.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = fwrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fwrt_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Acceptance never repeats back to back, and the controller is idle again after an execute
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !cmd.accept)
        else $error("accept in two consecutive cycles");
    a_exec_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> s_tready)
        else $error("controller not idle after execute");
`endif

endmodule

### rtl/fwrt_dp.sv
module fwrt_dp
#(
    parameter int DEPTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  fwrt_pkg::cmd_t                    cmd,
    output fwrt_pkg::stat_t                   stat,
    input  logic [fwrt_pkg::MODE_W-1:0]       in_mode,
    input  logic [fwrt_pkg::TAG_W-1:0]        in_tag,
    input  logic [fwrt_pkg::HANDLE_W-1:0]     in_handle,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fwrt_pkg::STATUS_W-1:0]     out_status,
    output logic                              out_removed_valid,
    output logic [fwrt_pkg::TAG_W-1:0]        out_removed_tag,
    output logic [fwrt_pkg::HANDLE_W-1:0]     out_removed_handle,
    output logic                              out_now_empty
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Queue cells, front at index 0
    logic [fwrt_pkg::TAG_W-1:0]    tag_reg    [DEPTH];
    logic [fwrt_pkg::HANDLE_W-1:0] handle_reg [DEPTH];
    logic [fwrt_pkg::TAG_W-1:0]    tag_next    [DEPTH];
    logic [fwrt_pkg::HANDLE_W-1:0] handle_next [DEPTH];
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;

    // Latched operation and match vector
    logic [fwrt_pkg::MODE_W-1:0]   mode_reg;
    logic [fwrt_pkg::TAG_W-1:0]    key_reg;
    logic [fwrt_pkg::HANDLE_W-1:0] hnd_reg;
    logic [DEPTH-1:0]              match_reg;
    logic [DEPTH-1:0]              match_next;

    // Result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [fwrt_pkg::STATUS_W-1:0] status_reg;
    logic                          rvalid_reg;
    logic [fwrt_pkg::TAG_W-1:0]    rtag_reg;
    logic [fwrt_pkg::HANDLE_W-1:0] rhandle_reg;
    logic                          empty_reg;

    // Execute-cycle signals
    logic                          is_empty;
    logic                          is_full;
    logic                          do_enq;
    logic                          do_remove;
    logic [DEPTH-1:0]              sel;
    logic [DEPTH-1:0]              shift_mask;
    logic [fwrt_pkg::TAG_W-1:0]    sel_tag;
    logic [fwrt_pkg::HANDLE_W-1:0] sel_handle;
    logic [fwrt_pkg::STATUS_W-1:0] status_next;

    assign stat.out_busy = out_valid_reg && !out_ready;

    // Parallel tag compare over the occupied cells
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_next[i] = (tag_reg[i] == in_tag) && (count_reg > CW'(i));
        end
    end

    // Operation decode
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));

    always_comb
    begin
        sel         = '0;
        do_enq      = 1'b0;
        status_next = fwrt_pkg::STAT_OK;
        case (mode_reg)
            fwrt_pkg::MODE_ENQ:
            begin
                if (is_full)
                begin
                    status_next = fwrt_pkg::STAT_FULL;
                end
                else
                begin
                    do_enq = cmd.exec;
                end
            end
            fwrt_pkg::MODE_DEQ:
            begin
                if (is_empty)
                begin
                    status_next = fwrt_pkg::STAT_EMPTY;
                end
                else
                begin
                    sel = DEPTH'(1);
                end
            end
            fwrt_pkg::MODE_REMOVE:
            begin
                if (is_empty)
                begin
                    status_next = fwrt_pkg::STAT_EMPTY;
                end
                else if (match_reg == '0)
                begin
                    status_next = fwrt_pkg::STAT_NOT_FOUND;
                end
                else
                begin
                    // oldest match: lowest set bit
                    sel = match_reg & (~match_reg + DEPTH'(1));
                end
            end
            default:
            begin
                status_next = fwrt_pkg::STAT_OK;
            end
        endcase
    end

    assign do_remove  = cmd.exec && (sel != '0);
    // cells at and behind the removed one take their successor
    assign shift_mask = ~(sel - DEPTH'(1));

    // Echo of the removed cell
    always_comb
    begin
        sel_tag    = '0;
        sel_handle = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_tag    = sel_tag    | (sel[i] ? tag_reg[i]    : '0);
            sel_handle = sel_handle | (sel[i] ? handle_reg[i] : '0);
        end
    end

    // Cell next values: compaction shift or rear write
    generate
        for (genvar g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g < DEPTH - 1)
            begin : g_mid
                always_comb
                begin
                    tag_next[g]    = tag_reg[g];
                    handle_next[g] = handle_reg[g];
                    if (do_remove && shift_mask[g])
                    begin
                        tag_next[g]    = tag_reg[g+1];
                        handle_next[g] = handle_reg[g+1];
                    end
                    else if (do_enq && (count_reg[IW-1:0] == IW'(g)))
                    begin
                        tag_next[g]    = key_reg;
                        handle_next[g] = hnd_reg;
                    end
                end
            end
            else
            begin : g_last
                always_comb
                begin
                    tag_next[g]    = tag_reg[g];
                    handle_next[g] = handle_reg[g];
                    if (do_enq && (count_reg[IW-1:0] == IW'(g)))
                    begin
                        tag_next[g]    = key_reg;
                        handle_next[g] = hnd_reg;
                    end
                end
            end
        end
    endgenerate

    // Fill count
    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            tag_reg[i]    <= tag_next[i];
            handle_reg[i] <= handle_next[i];
        end
        if (cmd.accept)
        begin
            mode_reg  <= in_mode;
            key_reg   <= in_tag;
            hnd_reg   <= in_handle;
            match_reg <= match_next;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            rvalid_reg  <= do_remove;
            rtag_reg    <= sel_tag;
            rhandle_reg <= sel_handle;
            empty_reg   <= (count_next == '0);
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_status         = status_reg;
    assign out_removed_valid  = rvalid_reg;
    assign out_removed_tag    = rtag_reg;
    assign out_removed_handle = rhandle_reg;
    assign out_now_empty      = empty_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> $onehot0(sel))
        else $error("more than one cell selected for removal");
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rvalid_reg) |-> (status_reg == fwrt_pkg::STAT_OK))
        else $error("removed entry with non-ok status");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        do_remove |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("removal did not shorten the queue");
`endif

endmodule

### tb/fifo_with_remove_by_tag_unit_tb.sv
module fifo_with_remove_by_tag_unit_tb;

    localparam int QDEPTH    = 16;
    localparam int LONG_HOLD = 60;

    localparam int MODE_W    = fwrt_pkg::MODE_W;
    localparam int TAG_W     = fwrt_pkg::TAG_W;
    localparam int HANDLE_W  = fwrt_pkg::HANDLE_W;
    localparam int STATUS_W  = fwrt_pkg::STATUS_W;
    localparam int S_TDATA_W = fwrt_pkg::S_TDATA_W;
    localparam int M_TDATA_W = fwrt_pkg::M_TDATA_W;

    // Mode 3 is unused by the block and must act as a no-op
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    typedef enum int
    {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_style_t;

    typedef struct packed
    {
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed
    {
        logic [STATUS_W-1:0] status;
        logic                removed_valid;
        logic [TAG_W-1:0]    removed_tag;
        logic [HANDLE_W-1:0] removed_handle;
        logic                now_empty;
    } result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // mode, tag, work_handle
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // status, removed_valid, removed_tag,
                                          // removed_handle, now_empty

    // Model of the queue contents, front at index 0
    entry_t    queue_model[$];
    result_t   pending_results[$];

    int        mismatch_count = 0;
    int        result_index = 0;
    bit        tx_gaps = 1'b1;
    int        burst_left = 0;
    rx_style_t rx_style = RX_RANDOM;
    int        hold_requests = 0;
    int        holds_served = 0;
    int        hold_left = 0;
    int        rx_phase = 0;

    fifo_with_remove_by_tag_unit #(.DEPTH(QDEPTH)) uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Applies one operation to the queue model and returns its result
    function automatic result_t predict_queue_op(input logic [MODE_W-1:0] mode,
                                                 input logic [TAG_W-1:0] tag,
                                                 input logic [HANDLE_W-1:0] handle);
        result_t r;
        int      hit;
        r = '0;
        r.status = fwrt_pkg::STAT_OK;
        hit = -1;
        case (mode)
            fwrt_pkg::MODE_ENQ:
            begin
                if (queue_model.size() >= QDEPTH)
                    r.status = fwrt_pkg::STAT_FULL;
                else
                    queue_model.push_back({tag, handle});
            end
            fwrt_pkg::MODE_DEQ:
            begin
                if (queue_model.size() == 0)
                    r.status = fwrt_pkg::STAT_EMPTY;
                else
                    hit = 0;
            end
            fwrt_pkg::MODE_REMOVE:
            begin
                if (queue_model.size() == 0)
                    r.status = fwrt_pkg::STAT_EMPTY;
                else
                begin
                    for (int i = 0; i < queue_model.size(); i++)
                    begin
                        if (hit < 0 && queue_model[i].tag == tag)
                            hit = i;
                    end
                    if (hit < 0)
                        r.status = fwrt_pkg::STAT_NOT_FOUND;
                end
            end
            default: ;
        endcase
        if (hit >= 0)
        begin
            r.removed_valid  = 1'b1;
            r.removed_tag    = queue_model[hit].tag;
            r.removed_handle = queue_model[hit].handle;
            queue_model.delete(hit);
        end
        r.now_empty = (queue_model.size() == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: result %0d %s: got %0h, expected %0h",
                 $time, result_index, what, got, want);
        mismatch_count++;
    endtask

    // Offer one operation; burst/gap shaping happens here
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [TAG_W-1:0] tag,
                           input logic [HANDLE_W-1:0] handle);
        int gap;
        if (tx_gaps && burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({handle, tag, mode});
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_queue_op(mode, tag, handle));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Random operation; percentages for no-op, enqueue, dequeue, rest is remove
    task automatic send_random_op(input int nop_pct, input int enq_pct, input int deq_pct,
                                  input bit narrow_tags);
        int                  pick;
        logic [MODE_W-1:0]   mode;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
        pick = $urandom_range(0, 99);
        if (pick < nop_pct)
            mode = MODE_NOP;
        else if (pick < nop_pct + enq_pct)
            mode = fwrt_pkg::MODE_ENQ;
        else if (pick < nop_pct + enq_pct + deq_pct)
            mode = fwrt_pkg::MODE_DEQ;
        else
            mode = fwrt_pkg::MODE_REMOVE;
        tag = narrow_tags ? TAG_W'($urandom_range(0, 7)) : TAG_W'($urandom_range(0, 255));
        // mostly search for a tag that is really held
        if (mode == fwrt_pkg::MODE_REMOVE && queue_model.size() != 0 &&
            $urandom_range(0, 3) != 0)
            tag = queue_model[$urandom_range(0, queue_model.size() - 1)].tag;
        handle = HANDLE_W'($urandom);
        send_op(mode, tag, handle);
    endtask

    // Receiver: ready pattern plus an on-demand long hold-off
    always @(posedge clk)
    begin
        rx_phase++;
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                default:    m_tready <= ((rx_phase % 8) < 5);
            endcase
        end
    end

    // Result checker: compare each transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transaction", m_tdata, '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
                if (m_tdata[2] !== want.removed_valid)
                    report_mismatch("removed_valid", 32'(m_tdata[2]),
                                    32'(want.removed_valid));
                if (m_tdata[10:3] !== want.removed_tag)
                    report_mismatch("removed_tag", 32'(m_tdata[10:3]),
                                    32'(want.removed_tag));
                if (m_tdata[26:11] !== want.removed_handle)
                    report_mismatch("removed_handle", 32'(m_tdata[26:11]),
                                    32'(want.removed_handle));
                if (m_tdata[27] !== want.now_empty)
                    report_mismatch("now_empty", 32'(m_tdata[27]), 32'(want.now_empty));
            end
            result_index++;
        end
    end

    // Operations on an empty queue, tag and handle unused
    task automatic test_empty_queue();
        send_op(fwrt_pkg::MODE_DEQ, 8'hFF, 16'hFFFF);
        send_op(fwrt_pkg::MODE_REMOVE, 8'hFF, 16'h0000);
        send_op(MODE_NOP, 8'hFF, 16'hFFFF);
    endtask

    // Field extremes and plain arrival order
    task automatic test_order_and_extremes();
        send_op(fwrt_pkg::MODE_ENQ, 8'h00, 16'h0000);
        send_op(fwrt_pkg::MODE_ENQ, 8'hFF, 16'hFFFF);
        send_op(fwrt_pkg::MODE_ENQ, 8'h5A, 16'h1234);
        send_op(MODE_NOP, 8'h00, 16'h0000);
        send_op(fwrt_pkg::MODE_DEQ, 8'hA5, 16'hFFFF);
        send_op(fwrt_pkg::MODE_DEQ, 8'h00, 16'h0000);
        send_op(fwrt_pkg::MODE_DEQ, 8'hFF, 16'h5555);
        send_op(fwrt_pkg::MODE_DEQ, 8'h00, 16'h0000);
    endtask

    // Oldest match wins, gap closes, misses leave the queue alone
    task automatic test_remove_by_tag();
        send_op(fwrt_pkg::MODE_ENQ, 8'd10, 16'h0A01);
        send_op(fwrt_pkg::MODE_ENQ, 8'd20, 16'h1401);
        send_op(fwrt_pkg::MODE_ENQ, 8'd30, 16'h1E01);
        send_op(fwrt_pkg::MODE_ENQ, 8'd20, 16'h1402);
        send_op(fwrt_pkg::MODE_REMOVE, 8'd20, 16'hFFFF);
        send_op(fwrt_pkg::MODE_REMOVE, 8'd99, 16'h0000);
        send_op(fwrt_pkg::MODE_REMOVE, 8'd20, 16'h0000);
        send_op(fwrt_pkg::MODE_REMOVE, 8'd10, 16'h0000);
        send_op(fwrt_pkg::MODE_DEQ, 8'd0, 16'h0000);
        send_op(fwrt_pkg::MODE_REMOVE, 8'd30, 16'h0000);
        wait_all_results();
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_output_stall();
        tx_gaps = 1'b0;
        rx_style <= RX_ALWAYS;
        hold_requests <= hold_requests + 1;
        repeat (12) send_random_op(0, 70, 15, 1'b1);
        wait_all_results();
        tx_gaps = 1'b1;
    endtask

    // Enqueue-heavy traffic to reach and sit at the full limit
    task automatic test_random_fill();
        rx_style <= RX_RANDOM;
        repeat (150) send_random_op(4, 66, 12, 1'b1);
        wait_all_results();
    endtask

    // Removal-heavy traffic to drain down to empty repeatedly
    task automatic test_random_drain();
        rx_style <= RX_PATTERN;
        repeat (100) send_random_op(4, 30, 30, 1'b1);
        wait_all_results();
    endtask

    // Balanced traffic with wide tags, then narrow tags at full rate
    task automatic test_random_mixed();
        rx_style <= RX_RANDOM;
        repeat (100) send_random_op(4, 45, 20, 1'b0);
        tx_gaps = 1'b0;
        rx_style <= RX_ALWAYS;
        repeat (100) send_random_op(4, 48, 20, 1'b1);
        tx_gaps = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_order_and_extremes();
        test_remove_by_tag();
        test_output_stall();
        test_random_fill();
        test_random_drain();
        test_random_mixed();
        wait_all_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("fifo_with_remove_by_tag_unit regression: pass");
        else
            $display("fifo_with_remove_by_tag_unit regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("fifo_with_remove_by_tag_unit regression: fail");
        $finish;
    end

endmodule
